@@ sv/ppdr_pkg.sv @@
package ppdr_pkg;

    // Configuration of the pose arithmetic
    localparam int CORDIC_ITERATIONS = 16;
    localparam int POS_FRAC_BITS     = 16;

    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;
    localparam int ITERS        = (CORDIC_ITERATIONS < ATAN_ENTRIES) ? CORDIC_ITERATIONS
                                                                     : ATAN_ENTRIES;
    localparam int ITER_W       = (ITERS > 1) ? $clog2(ITERS) : 1;

    // Field widths
    localparam int POS_W  = 32;
    localparam int HEAD_W = 16;
    localparam int FWD_W  = 24;
    localparam int TURN_W = 16;

    // Datapath widths
    localparam int FWD_FRAC  = 16;
    localparam int TRIG_FRAC = 30;
    localparam int TRIG_W    = 34;
    localparam int ANG_W     = 33;
    localparam int PROD_W    = FWD_W + TRIG_W;
    localparam int SH        = FWD_FRAC + TRIG_FRAC - POS_FRAC_BITS;
    localparam int D_W       = PROD_W - SH;
    localparam int SUM_W     = ((D_W > POS_W) ? D_W : POS_W) + 1;

    localparam logic signed [TRIG_W-1:0] INV_GAIN = TRIG_W'(32'h26DD3B6A);

    // Stream packing
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CINIT,
        ST_CROT,
        ST_MULX,
        ST_ACCX,
        ST_MULY,
        ST_ACCY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              capture;
        logic              cinit;
        logic              crot;
        logic [ITER_W-1:0] iter;
        logic              mul;
        logic              acc;
        logic              axis_y;
        logic              out_load;
    } cmd_t;

    // Arctangent of 2^-i, 2^32 units per circle
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051D;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2E;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return ANG_W'(v);
    endfunction

endpackage

@@ sv/ppdr_ctrl.sv @@
module ppdr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_mode,
    output logic          s_ready,
    input  logic          m_ready,
    output logic          m_valid,
    output ppdr_pkg::cmd_t cmd
);

    ppdr_pkg::state_t state_reg, state_next;
    logic [ppdr_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic out_valid_reg, out_valid_next;

    // State, iteration counter and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ppdr_pkg::ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequence one transaction through the datapath
    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.iter   = iter_reg;
        unique case (state_reg)
            ppdr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = s_mode ? ppdr_pkg::ST_DONE : ppdr_pkg::ST_CINIT;
                end
            end
            ppdr_pkg::ST_CINIT: begin
                cmd.cinit  = 1'b1;
                iter_next  = '0;
                state_next = ppdr_pkg::ST_CROT;
            end
            ppdr_pkg::ST_CROT: begin
                cmd.crot = 1'b1;
                if (iter_reg == ppdr_pkg::ITER_W'(ppdr_pkg::ITERS - 1)) begin
                    state_next = ppdr_pkg::ST_MULX;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ppdr_pkg::ST_MULX: begin
                cmd.mul    = 1'b1;
                state_next = ppdr_pkg::ST_ACCX;
            end
            ppdr_pkg::ST_ACCX: begin
                cmd.acc    = 1'b1;
                state_next = ppdr_pkg::ST_MULY;
            end
            ppdr_pkg::ST_MULY: begin
                cmd.mul    = 1'b1;
                cmd.axis_y = 1'b1;
                state_next = ppdr_pkg::ST_ACCY;
            end
            ppdr_pkg::ST_ACCY: begin
                cmd.acc    = 1'b1;
                cmd.axis_y = 1'b1;
                state_next = ppdr_pkg::ST_DONE;
            end
            ppdr_pkg::ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ppdr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ppdr_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the result until the downstream side takes it
    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

    a_setpose_skips_cordic: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture && s_mode |=> state_reg == ppdr_pkg::ST_DONE)
        else $error("set pose did not go straight to output");

    a_iter_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ppdr_pkg::ST_CROT |->
            iter_reg <= ppdr_pkg::ITER_W'(ppdr_pkg::ITERS - 1))
        else $error("CORDIC iteration count overran");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !out_valid_reg || m_ready)
        else $error("pending result overwritten");

    a_y_then_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ppdr_pkg::ST_ACCY |=> state_reg == ppdr_pkg::ST_DONE)
        else $error("y update not followed by output");

endmodule

@@ sv/ppdr_datapath.sv @@
module ppdr_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ppdr_pkg::cmd_t                      cmd,
    input  logic                                s_mode,
    input  logic signed [ppdr_pkg::POS_W-1:0]   s_pos_x,
    input  logic signed [ppdr_pkg::POS_W-1:0]   s_pos_y,
    input  logic [ppdr_pkg::HEAD_W-1:0]         s_heading,
    input  logic signed [ppdr_pkg::FWD_W-1:0]   s_forward,
    input  logic signed [ppdr_pkg::TURN_W-1:0]  s_turn,
    output logic signed [ppdr_pkg::POS_W-1:0]   out_x,
    output logic signed [ppdr_pkg::POS_W-1:0]   out_y,
    output logic [ppdr_pkg::HEAD_W-1:0]         out_heading,
    output logic                                saturated
);

    // Pose state
    logic signed [ppdr_pkg::POS_W-1:0]  x_pos_reg, y_pos_reg;
    logic [ppdr_pkg::HEAD_W-1:0]        head_reg;
    logic                               sat_reg;

    // Working registers
    logic signed [ppdr_pkg::FWD_W-1:0]  fwd_reg;
    logic signed [ppdr_pkg::TRIG_W-1:0] cx_reg, cy_reg;
    logic signed [ppdr_pkg::ANG_W-1:0]  cz_reg;
    logic                               flip_reg;
    logic signed [ppdr_pkg::PROD_W-1:0] prod_reg;

    // Output registers
    logic signed [ppdr_pkg::POS_W-1:0]  out_x_reg, out_y_reg;
    logic [ppdr_pkg::HEAD_W-1:0]        out_head_reg;
    logic                               out_sat_reg;

    logic                               flip_c;
    logic [ppdr_pkg::HEAD_W-1:0]        fold_c;
    logic signed [ppdr_pkg::TRIG_W-1:0] dx_c, dy_c, trig_c, trig_f_c;
    logic signed [ppdr_pkg::ANG_W-1:0]  atan_c;
    logic signed [ppdr_pkg::PROD_W-1:0] rsum_c;
    logic signed [ppdr_pkg::D_W-1:0]    d_c;
    logic signed [ppdr_pkg::POS_W-1:0]  pos_c, pos_new_c;
    logic signed [ppdr_pkg::SUM_W-1:0]  sum_c;
    logic                               sat_hi_c, sat_lo_c;

    // Fold heading into the right half plane
    assign flip_c = head_reg[ppdr_pkg::HEAD_W-1] ^ head_reg[ppdr_pkg::HEAD_W-2];
    assign fold_c = {head_reg[ppdr_pkg::HEAD_W-1] ^ flip_c, head_reg[ppdr_pkg::HEAD_W-2:0]};

    // One CORDIC rotation
    assign dx_c   = cy_reg >>> cmd.iter;
    assign dy_c   = cx_reg >>> cmd.iter;
    assign atan_c = ppdr_pkg::atan_entry(ppdr_pkg::ATAN_IDX_W'(cmd.iter));

    // Select and unfold the trig value
    assign trig_c   = cmd.axis_y ? cy_reg : cx_reg;
    assign trig_f_c = flip_reg ? -trig_c : trig_c;

    // Round the step, add and saturate
    assign rsum_c = prod_reg + (ppdr_pkg::PROD_W'(1) <<< (ppdr_pkg::SH - 1));
    assign d_c    = rsum_c[ppdr_pkg::PROD_W-1:ppdr_pkg::SH];
    assign pos_c  = cmd.axis_y ? y_pos_reg : x_pos_reg;
    assign sum_c  = ppdr_pkg::SUM_W'(pos_c) + ppdr_pkg::SUM_W'(d_c);
    assign sat_hi_c = !sum_c[ppdr_pkg::SUM_W-1] &&
                      (|sum_c[ppdr_pkg::SUM_W-2:ppdr_pkg::POS_W-1]);
    assign sat_lo_c = sum_c[ppdr_pkg::SUM_W-1] &&
                      !(&sum_c[ppdr_pkg::SUM_W-2:ppdr_pkg::POS_W-1]);

    always_comb begin
        if (sat_hi_c) begin
            pos_new_c = {1'b0, {(ppdr_pkg::POS_W-1){1'b1}}};
        end else if (sat_lo_c) begin
            pos_new_c = {1'b1, {(ppdr_pkg::POS_W-1){1'b0}}};
        end else begin
            pos_new_c = sum_c[ppdr_pkg::POS_W-1:0];
        end
    end

    // Pose state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_pos_reg <= '0;
            y_pos_reg <= '0;
            head_reg  <= '0;
            sat_reg   <= 1'b0;
        end else begin
            if (cmd.capture) begin
                sat_reg <= 1'b0;
                if (s_mode) begin
                    x_pos_reg <= s_pos_x;
                    y_pos_reg <= s_pos_y;
                    head_reg  <= s_heading;
                end else begin
                    head_reg <= head_reg + s_turn;
                end
            end
            if (cmd.acc) begin
                if (cmd.axis_y) begin
                    y_pos_reg <= pos_new_c;
                end else begin
                    x_pos_reg <= pos_new_c;
                end
                sat_reg <= sat_reg | sat_hi_c | sat_lo_c;
            end
        end
    end

    // CORDIC and multiplier registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            fwd_reg <= s_forward;
        end
        if (cmd.cinit) begin
            flip_reg <= flip_c;
            cx_reg   <= ppdr_pkg::INV_GAIN;
            cy_reg   <= '0;
            cz_reg   <= {{(ppdr_pkg::ANG_W-32){fold_c[ppdr_pkg::HEAD_W-1]}}, fold_c, 16'h0000};
        end else if (cmd.crot) begin
            if (!cz_reg[ppdr_pkg::ANG_W-1]) begin
                cx_reg <= cx_reg - dx_c;
                cy_reg <= cy_reg + dy_c;
                cz_reg <= cz_reg - atan_c;
            end else begin
                cx_reg <= cx_reg + dx_c;
                cy_reg <= cy_reg - dy_c;
                cz_reg <= cz_reg + atan_c;
            end
        end
        if (cmd.mul) begin
            prod_reg <= fwd_reg * trig_f_c;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_x_reg    <= x_pos_reg;
            out_y_reg    <= y_pos_reg;
            out_head_reg <= head_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_heading = out_head_reg;
    assign saturated   = out_sat_reg;

    a_setpose_clears_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture && s_mode |=> !sat_reg)
        else $error("saturation flag set after set pose");

    a_turn_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture && !s_mode |=>
            head_reg == ppdr_pkg::HEAD_W'($past(head_reg) + $past(s_turn)))
        else $error("heading update wrong");

endmodule

@@ sv/planar_pose_dead_reckoning.sv @@
// Planar pose dead reckoning: keeps x, y (signed Q16.16) and a 16-bit binary heading.
// A set-pose transaction (tuser = 1) loads the pose and goes straight to the output
// register. A move transaction (tuser = 0) adds the turn to the heading, then runs
// an iterative CORDIC (one rotation per cycle) and a shared multiplier that scales
// the forward distance by cos and then sin before each saturating add. In both cases
// the next transaction can be accepted in the same cycle as the result appears. A
// finished transaction whose predecessor still waits in the output register holds
// until the downstream side takes that result. One transaction is in work at a time;
// a new one is accepted while the previous result still waits in the output register.
// Each transaction gives exactly one result.
module planar_pose_dead_reckoning (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pos_x[31:0], pos_y[63:32], heading[79:64], forward[103:80], turn[119:104]
    input  logic [ppdr_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // mode[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_x[31:0], out_y[63:32], out_heading[79:64]
    output logic [ppdr_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // saturated[0]
    output logic                               m_axis_tuser
);

    ppdr_pkg::cmd_t cmd;

    logic signed [ppdr_pkg::POS_W-1:0] out_x, out_y;
    logic [ppdr_pkg::HEAD_W-1:0]       out_heading;
    logic                              saturated;

    // Sequencer
    ppdr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_mode  (s_axis_tuser),
        .s_ready (s_axis_tready),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .cmd     (cmd)
    );

    // Pose arithmetic
    ppdr_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_mode      (s_axis_tuser),
        .s_pos_x     (s_axis_tdata[31:0]),
        .s_pos_y     (s_axis_tdata[63:32]),
        .s_heading   (s_axis_tdata[79:64]),
        .s_forward   (s_axis_tdata[103:80]),
        .s_turn      (s_axis_tdata[119:104]),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_heading (out_heading),
        .saturated   (saturated)
    );

    assign m_axis_tdata = {out_heading, out_y, out_x};
    assign m_axis_tuser = saturated;

endmodule
